/* rtl/pd_line_follower_drive_top_assert.svh */
// Assertion macros for the line follower drive block.
// Used by modules that carry i_clk and i_rst_n ports.
`ifndef PD_LINE_FOLLOWER_DRIVE_TOP_ASSERT_SVH
`define PD_LINE_FOLLOWER_DRIVE_TOP_ASSERT_SVH

// Checked property, disabled while reset is asserted.
`define PDLF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked property, also active during reset.
`define PDLF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/pdlf_pkg.sv */
// Shared types and constants of the line follower drive block.
// No dependencies.
`default_nettype none

package pdlf_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WHITE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PGAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DGAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END    = 3'd5;

    localparam logic [15:0] RST_SPAN   = 16'd18500;
    localparam logic [7:0]  RST_BASE   = 8'd220;
    localparam logic [7:0]  RST_PGAIN  = 8'd50;
    localparam logic [7:0]  RST_DGAIN  = 8'd60;
    localparam logic [3:0]  RST_END    = 4'd3;

    // result kinds
    localparam logic [1:0] KIND_DONE = 2'd0;
    localparam logic [1:0] KIND_SPIN = 2'd1;
    localparam logic [1:0] KIND_PD   = 2'd2;

    // line events
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_REGAIN = 2'd1;
    localparam logic [1:0] EV_LOSS   = 2'd2;

    // error divider: 19 quotient bits, one per cycle
    localparam int DIV_STEPS = 19;
    localparam int STEP_W    = 5;

    localparam logic [18:0] ERR_MAG_MAX = 19'h7FFFF;
    localparam logic [7:0]  SPEED_MAX   = 8'd255;

    typedef struct packed {
        logic edge_l;
        logic outer_l;
        logic inner_l;
        logic inner_r;
        logic outer_r;
        logic edge_r;
    } t_flags;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic err_apply;
        logic mul_p;
        logic mul_d;
        logic sum;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic pd_path;
        logic div_skip;
    } t_dp_stat;

endpackage

`default_nettype wire

/* rtl/pdlf_dpath.sv */
// Datapath: configuration registers, line/crossing state, error divider,
// PD multiplies and wheel speed shaping. Depends on pdlf_pkg.
`default_nettype none

module pdlf_dpath
    import pdlf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [15:0]           i_outer_left_level,
    input  wire logic [15:0]           i_inner_left_level,
    input  wire logic [15:0]           i_inner_right_level,
    input  wire logic [15:0]           i_outer_right_level,
    input  wire t_flags                i_flags,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    output logic [7:0]                 o_left_speed,
    output logic [7:0]                 o_right_speed,
    output logic                       o_search_turn,
    output logic                       o_crossing,
    output logic [3:0]                 o_line_count,
    output logic                       o_course_done,
    output logic [1:0]                 o_line_event
);

    // configuration (white level cancels in the error and is not stored)
    logic [15:0] r_span;
    logic [7:0]  r_base, r_pgain, r_dgain;
    logic [3:0]  r_end_cnt;

    // control state
    logic        r_finished, r_searching, r_off_line, r_armed, r_turn_right;
    logic [3:0]  r_count;
    logic signed [3:0] r_prev;

    // per item
    t_flags             r_flags;
    logic signed [20:0] r_num;
    logic [1:0]         r_kind, r_ev;
    logic               r_cross, r_neg, r_sat, r_zero;
    logic [18:0]        r_rem, r_quo, r_dvd_lo, r_dsr;
    logic signed [19:0] r_err;
    logic signed [20:0] r_diff;
    logic signed [28:0] r_prod_p;
    logic signed [29:0] r_prod_d;
    logic signed [13:0] r_corr;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span    <= RST_SPAN;
            r_base    <= RST_BASE;
            r_pgain   <= RST_PGAIN;
            r_dgain   <= RST_DGAIN;
            r_end_cnt <= RST_END;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WHITE: ;
                CFG_SPAN:  r_span    <= i_cfg_data;
                CFG_BASE:  r_base    <= i_cfg_data[7:0];
                CFG_PGAIN: r_pgain   <= i_cfg_data[7:0];
                CFG_DGAIN: r_dgain   <= i_cfg_data[7:0];
                CFG_END:   r_end_cnt <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ---------------- numerator 9*(ol-or) + 5*(il-ir) ----------------
    logic signed [16:0] d_outer, d_inner;
    logic signed [20:0] n_num;

    assign d_outer = $signed({1'b0, i_outer_left_level}) - $signed({1'b0, i_outer_right_level});
    assign d_inner = $signed({1'b0, i_inner_left_level}) - $signed({1'b0, i_inner_right_level});
    assign n_num = $signed({d_outer[16], d_outer, 3'b000}) + $signed({{4{d_outer[16]}}, d_outer})
                 + $signed({{2{d_inner[16]}}, d_inner, 2'b00})
                 + $signed({{4{d_inner[16]}}, d_inner});

    // ---------------- evaluation of events and crossings ----------------
    logic       any_inner;
    logic       off_n, armed_n, cross_n, fin_n;
    logic [1:0] ev_n;
    logic [3:0] count_n;

    assign any_inner = r_flags.outer_l | r_flags.inner_l | r_flags.inner_r | r_flags.outer_r;

    always_comb begin
        off_n   = r_off_line;
        ev_n    = EV_NONE;
        if (r_off_line && r_flags.inner_l && r_flags.inner_r) begin
            off_n = 1'b0;
            ev_n  = EV_REGAIN;
        end else if (!r_off_line && !r_flags.inner_l && !r_flags.inner_r) begin
            off_n = 1'b1;
            ev_n  = EV_LOSS;
        end
        armed_n = r_armed | (!r_flags.edge_l & !r_flags.edge_r);
        count_n = r_count;
        cross_n = 1'b0;
        if (armed_n && r_flags.edge_l && r_flags.edge_r) begin
            if (r_count != 4'hF) begin
                count_n = r_count + 4'd1;
            end
            armed_n = 1'b0;
            cross_n = 1'b1;
        end
        fin_n = (count_n >= r_end_cnt);
    end

    // magnitude, divisor 5*span and saturation test (|N| >= 8*D)
    logic [20:0] num_abs;
    logic [19:0] mag;
    logic [18:0] dsr;
    logic        sat, zero;

    assign num_abs = r_num[20] ? (~r_num + 21'd1) : r_num;
    assign mag     = num_abs[19:0];
    assign dsr     = {1'b0, r_span, 2'b00} + {3'b000, r_span};
    assign sat     = {2'b00, mag} >= {dsr, 3'b000};
    assign zero    = (r_num == 21'sd0);

    assign o_stat.pd_path  = !r_finished && !r_searching && !fin_n;
    assign o_stat.div_skip = sat || zero;

    // ---------------- divider step ----------------
    logic [19:0] div_t, div_d;
    logic        div_ge;

    assign div_t  = {r_rem, r_dvd_lo[18]};
    assign div_ge = div_t >= {1'b0, r_dsr};
    assign div_d  = div_t - {1'b0, r_dsr};

    // ---------------- error, PD terms ----------------
    logic [18:0]        err_mag;
    logic [20:0]        err_bias;
    logic signed [3:0]  prev_n;
    logic signed [30:0] pd_sum, pd_bias;

    assign err_mag  = r_zero ? 19'd0 : (r_sat ? ERR_MAG_MAX : r_quo);
    assign err_bias = {r_err[19], r_err} + (r_err[19] ? 21'd65535 : 21'd0);
    assign prev_n   = err_bias[19:16];
    assign pd_sum   = {{2{r_prod_p[28]}}, r_prod_p} + {r_prod_d[29], r_prod_d};
    assign pd_bias  = pd_sum + (pd_sum[30] ? 31'sd65535 : 31'sd0);

    // ---------------- wheel speeds ----------------
    logic signed [16:0] corr_x, base_x, left0, right0, lf, rf, adj;
    logic [7:0]         spd_l, spd_r;

    assign corr_x = {{3{r_corr[13]}}, r_corr};
    assign base_x = {9'b0, r_base};
    assign left0  = base_x - corr_x;
    assign right0 = base_x + corr_x;
    assign lf     = left0[16]  ? 17'sd0 : left0;
    assign rf     = right0[16] ? 17'sd0 : right0;

    always_comb begin
        spd_l = lf[7:0];
        spd_r = rf[7:0];
        adj   = 17'sd0;
        if (lf > 17'sd255) begin
            // spill twice the left overflow onto the right wheel
            adj   = rf - ((lf - 17'sd255) <<< 1);
            spd_l = SPEED_MAX;
            spd_r = adj[16] ? 8'd0 : adj[7:0];
        end else if (rf > 17'sd255) begin
            adj   = lf - ((rf - 17'sd255) <<< 1);
            spd_r = SPEED_MAX;
            spd_l = adj[16] ? 8'd0 : adj[7:0];
        end
    end

    logic spin;
    assign spin = (r_kind == KIND_SPIN) || ((r_kind == KIND_PD) && !any_inner);

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_finished   <= 1'b0;
            r_searching  <= 1'b0;
            r_off_line   <= 1'b0;
            r_armed      <= 1'b1;
            r_turn_right <= 1'b0;
            r_count      <= 4'd0;
            r_prev       <= 4'sd0;
        end else begin
            if (i_cmd.eval && !r_finished) begin
                if (r_searching) begin
                    if (any_inner) begin
                        r_searching <= 1'b0;
                    end
                end else begin
                    r_off_line <= off_n;
                    r_armed    <= armed_n;
                    r_count    <= count_n;
                    r_finished <= fin_n;
                end
            end
            if (i_cmd.mul_d) begin
                r_prev       <= prev_n;
                r_turn_right <= r_err[19] || (r_err == 20'sd0);
            end
            if (i_cmd.out_load && (r_kind == KIND_PD) && !any_inner) begin
                r_searching <= 1'b1;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_flags <= i_flags;
            r_num   <= n_num;
        end
        if (i_cmd.eval) begin
            r_neg    <= r_num[20];
            r_sat    <= sat;
            r_zero   <= zero;
            r_dsr    <= dsr;
            r_rem    <= {2'b00, mag[19:3]};
            r_dvd_lo <= {mag[2:0], 16'b0};
            r_quo    <= 19'd0;
            if (r_finished) begin
                r_kind  <= KIND_DONE;
                r_ev    <= EV_NONE;
                r_cross <= 1'b0;
            end else if (r_searching) begin
                r_kind  <= KIND_SPIN;
                r_ev    <= EV_NONE;
                r_cross <= 1'b0;
            end else begin
                r_kind  <= fin_n ? KIND_DONE : KIND_PD;
                r_ev    <= ev_n;
                r_cross <= cross_n;
            end
        end
        if (i_cmd.div_step) begin
            r_rem    <= div_ge ? div_d[18:0] : div_t[18:0];
            r_quo    <= {r_quo[17:0], div_ge};
            r_dvd_lo <= {r_dvd_lo[17:0], 1'b0};
        end
        if (i_cmd.err_apply) begin
            r_err <= r_neg ? -$signed({1'b0, err_mag}) : $signed({1'b0, err_mag});
        end
        if (i_cmd.mul_p) begin
            r_prod_p <= $signed({1'b0, r_pgain}) * r_err;
            r_diff   <= $signed({r_err[19], r_err}) - $signed({r_prev[3], r_prev, 16'b0});
        end
        if (i_cmd.mul_d) begin
            r_prod_d <= $signed({1'b0, r_dgain}) * r_diff;
        end
        if (i_cmd.sum) begin
            r_corr <= pd_bias[29:16];
        end
        if (i_cmd.out_load) begin
            if (r_kind == KIND_DONE) begin
                o_left_speed  <= 8'd0;
                o_right_speed <= 8'd0;
            end else if (spin) begin
                o_left_speed  <= r_turn_right ? SPEED_MAX : 8'd0;
                o_right_speed <= r_turn_right ? 8'd0 : SPEED_MAX;
            end else begin
                o_left_speed  <= spd_l;
                o_right_speed <= spd_r;
            end
            o_search_turn <= spin;
            o_crossing    <= r_cross;
            o_line_count  <= r_count;
            o_course_done <= (r_kind == KIND_DONE);
            o_line_event  <= r_ev;
        end
    end

endmodule

`default_nettype wire

/* rtl/pdlf_ctrl.sv */
// Controller: sequences one item through evaluation, division, PD and output.
// Depends on pdlf_pkg and pd_line_follower_drive_top_assert.svh.
`default_nettype none

`include "pd_line_follower_drive_top_assert.svh"

module pdlf_ctrl
    import pdlf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire logic     i_out_stall,
    output logic          o_out_valid,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_ERR  = 3'd3;
    localparam logic [2:0] S_MULP = 3'd4;
    localparam logic [2:0] S_MULD = 3'd5;
    localparam logic [2:0] S_SUM  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_step     = '0;
                if (!i_stat.pd_path) begin
                    n_state = S_OUT;
                end else if (i_stat.div_skip) begin
                    n_state = S_ERR;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_ERR;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_ERR: begin
                o_cmd.err_apply = 1'b1;
                n_state         = S_MULP;
            end
            S_MULP: begin
                o_cmd.mul_p = 1'b1;
                n_state     = S_MULD;
            end
            S_MULD: begin
                o_cmd.mul_d = 1'b1;
                n_state     = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `PDLF_ASSERT(a_load_slot_free, o_cmd.out_load |-> (!r_out_valid || !i_out_stall), "result overwritten while stalled")
    `PDLF_ASSERT(a_accept_to_eval, (r_state == S_IDLE && i_in_valid) |=> (r_state == S_EVAL), "accepted item not evaluated")
    `PDLF_ASSERT(a_div_len, (r_state == S_DIV && r_step == STEP_W'(DIV_STEPS - 1)) |=> (r_state == S_ERR), "divider step count off")
    `PDLF_ASSERT(a_valid_from_load, $rose(r_out_valid) |-> $past(o_cmd.out_load), "result valid without a load")

endmodule

`default_nettype wire

/* rtl/pd_line_follower_drive_top.sv */
// Flow: an accepted sample goes through EVAL, the restoring divider (DIV), ERR,
// the two multiplies (MULP, MULD), SUM and OUT; DIV is skipped on a saturated
// or zero error, and a done course or a spin during the line search goes from EVAL to OUT.
// Items are handled one at a time and taken only in IDLE; an item is taken
// while the previous result waits in the output register; OUT waits until taken.
// Reset: synchronous, active low; restores configuration and control-state defaults, no clear pass.
`default_nettype none

module pd_line_follower_drive_top
    import pdlf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // sample channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [15:0]           i_outer_left_level,
    input  wire logic [15:0]           i_inner_left_level,
    input  wire logic [15:0]           i_inner_right_level,
    input  wire logic [15:0]           i_outer_right_level,
    input  wire logic                  i_edge_left_on,
    input  wire logic                  i_outer_left_on,
    input  wire logic                  i_inner_left_on,
    input  wire logic                  i_inner_right_on,
    input  wire logic                  i_outer_right_on,
    input  wire logic                  i_edge_right_on,
    // drive result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [7:0]                 o_left_speed,
    output logic [7:0]                 o_right_speed,
    output logic                       o_search_turn,
    output logic                       o_crossing,
    output logic [3:0]                 o_line_count,
    output logic                       o_course_done,
    output logic [1:0]                 o_line_event
);

    // Flow of one item:
    //   IDLE  latch the sample and form N = 9*(ol-or) + 5*(il-ir)
    //   EVAL  line events, crossing count, course end; decide the path
    //   DIV   |N|*2^16 / (5*span), one quotient bit per cycle
    //         (skipped when the result saturates or N is zero)
    //   ERR   apply sign and saturation -> Q4.16 error
    //   MULP  prop_gain * e
    //   MULD  deriv_gain * (e - prev*2^16); prev and turn side updated
    //   SUM   correction, truncated toward zero
    //   OUT   wheel speeds with overflow spill, or spin / stop result

    t_flags   flags;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign flags.edge_l  = i_edge_left_on;
    assign flags.outer_l = i_outer_left_on;
    assign flags.inner_l = i_inner_left_on;
    assign flags.inner_r = i_inner_right_on;
    assign flags.outer_r = i_outer_right_on;
    assign flags.edge_r  = i_edge_right_on;

    pdlf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pdlf_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_outer_left_level  (i_outer_left_level),
        .i_inner_left_level  (i_inner_left_level),
        .i_inner_right_level (i_inner_right_level),
        .i_outer_right_level (i_outer_right_level),
        .i_flags             (flags),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .o_left_speed        (o_left_speed),
        .o_right_speed       (o_right_speed),
        .o_search_turn       (o_search_turn),
        .o_crossing          (o_crossing),
        .o_line_count        (o_line_count),
        .o_course_done       (o_course_done),
        .o_line_event        (o_line_event)
    );

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for pd_line_follower_drive_top: random and directed samples,
// an in-bench predictor of the drive results, valid/stall idling on both channels.
// Depends on pdlf_pkg and the block's RTL only.

module tb;
    import pdlf_pkg::*;

    // One reflectance sample as it goes over the input channel.
    typedef struct packed {
        logic [15:0] outer_l_lvl;
        logic [15:0] inner_l_lvl;
        logic [15:0] inner_r_lvl;
        logic [15:0] outer_r_lvl;
        t_flags      flags;
    } t_sample;

    // One drive result.
    typedef struct packed {
        logic [7:0] left_spd;
        logic [7:0] right_spd;
        logic       spin;
        logic       crossed;
        logic [3:0] count;
        logic       done;
        logic [1:0] line_ev;
    } t_drive;

    localparam longint Q_ONE = 65536;
    // Indexes past the last register: writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // DUT ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [15:0]           i_outer_left_level = '0;
    logic [15:0]           i_inner_left_level = '0;
    logic [15:0]           i_inner_right_level = '0;
    logic [15:0]           i_outer_right_level = '0;
    logic                  i_edge_left_on = 1'b0;
    logic                  i_outer_left_on = 1'b0;
    logic                  i_inner_left_on = 1'b0;
    logic                  i_inner_right_on = 1'b0;
    logic                  i_outer_right_on = 1'b0;
    logic                  i_edge_right_on = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [7:0]            o_left_speed;
    logic [7:0]            o_right_speed;
    logic                  o_search_turn;
    logic                  o_crossing;
    logic [3:0]            o_line_count;
    logic                  o_course_done;
    logic [1:0]            o_line_event;

    pd_line_follower_drive_top u_dut (.*);

    always #10 i_clk = ~i_clk;

    // Register mirror
    logic [15:0] white_lvl;
    logic [15:0] span_cfg;
    logic [7:0]  base_cfg;
    logic [7:0]  pgain_cfg;
    logic [7:0]  dgain_cfg;
    logic [3:0]  end_cfg;

    // Controller state mirror
    logic signed [3:0] prev_whole;
    logic              turn_right;
    logic              lost_flag;
    logic              armed;
    logic              in_search;
    logic              course_over;
    logic [3:0]        lines_seen;

    // Bench bookkeeping
    t_sample sample_queue[$];
    t_drive  drive_expected[$];
    int      n_queued = 0;
    int      n_accepted = 0;
    int      n_errors = 0;
    int      edge_pairs_left = 13;  // keeps the crossing count below 15 until the end
    bit      idle_on = 1'b1;
    bit      in_took = 1'b0;
    bit      out_took = 1'b0;
    int      in_gap = 0;
    int      out_wait = 0;
    int      out_hold = 0;

    task automatic model_reset();
        white_lvl   = 16'd5500;
        span_cfg    = RST_SPAN;
        base_cfg    = RST_BASE;
        pgain_cfg   = RST_PGAIN;
        dgain_cfg   = RST_DGAIN;
        end_cfg     = RST_END;
        prev_whole  = '0;
        turn_right  = 1'b0;
        lost_flag   = 1'b0;
        armed       = 1'b1;
        in_search   = 1'b0;
        course_over = 1'b0;
        lines_seen  = '0;
    endtask

    // Full spin toward the side where the line was last seen.
    function automatic void spin_speeds(inout t_drive r);
        r.spin      = 1'b1;
        r.left_spd  = turn_right ? SPEED_MAX : 8'd0;
        r.right_spd = turn_right ? 8'd0 : SPEED_MAX;
    endfunction

    // Works out the drive result of one sample and advances the state mirror.
    function automatic t_drive drive_predict(input t_sample s);
        t_drive r;
        logic   any_inner;
        longint num, err, corr, lspd, rspd;
        r = '0;
        any_inner = s.flags.outer_l | s.flags.inner_l | s.flags.inner_r | s.flags.outer_r;
        if (course_over) begin
            r.done  = 1'b1;
            r.count = lines_seen;
            return r;
        end
        // while hunting for the line: spin only, nothing else moves
        if (in_search) begin
            spin_speeds(r);
            r.count = lines_seen;
            if (any_inner)
                in_search = 1'b0;
            return r;
        end
        if (lost_flag && s.flags.inner_l && s.flags.inner_r) begin
            lost_flag = 1'b0;
            r.line_ev = EV_REGAIN;
        end else if (!lost_flag && !s.flags.inner_l && !s.flags.inner_r) begin
            lost_flag = 1'b1;
            r.line_ev = EV_LOSS;
        end
        if (!armed && !s.flags.edge_l && !s.flags.edge_r)
            armed = 1'b1;
        if (armed && s.flags.edge_l && s.flags.edge_r) begin
            if (lines_seen != 4'hF)
                lines_seen = lines_seen + 4'd1;
            armed = 1'b0;
            r.crossed = 1'b1;
        end
        r.count = lines_seen;
        if (lines_seen >= end_cfg) begin
            course_over = 1'b1;
            r.done = 1'b1;
            return r;
        end
        // weighted error, outer sensors 9/5, in Q4.16
        num = (9 * (longint'(s.outer_l_lvl) - longint'(s.outer_r_lvl)) +
               5 * (longint'(s.inner_l_lvl) - longint'(s.inner_r_lvl))) * Q_ONE;
        if (span_cfg == 16'd0) begin
            err = (num > 0) ? longint'(ERR_MAG_MAX) : ((num < 0) ? -longint'(ERR_MAG_MAX) : 0);
        end else begin
            err = num / (5 * longint'(span_cfg));
            if (err > longint'(ERR_MAG_MAX))
                err = longint'(ERR_MAG_MAX);
            if (err < -longint'(ERR_MAG_MAX))
                err = -longint'(ERR_MAG_MAX);
        end
        corr = (longint'(pgain_cfg) * err +
                longint'(dgain_cfg) * (err - longint'(prev_whole) * Q_ONE)) / Q_ONE;
        prev_whole = 4'(err / Q_ONE);
        turn_right = (err <= 0);
        if (!any_inner) begin
            in_search = 1'b1;
            spin_speeds(r);
            return r;
        end
        lspd = longint'(base_cfg) - corr;
        rspd = longint'(base_cfg) + corr;
        if (lspd < 0)
            lspd = 0;
        if (rspd < 0)
            rspd = 0;
        // overflow on one wheel is taken twice off the other
        if (lspd > 255) begin
            rspd = rspd - 2 * (lspd - 255);
            lspd = 255;
            if (rspd < 0)
                rspd = 0;
        end else if (rspd > 255) begin
            lspd = lspd - 2 * (rspd - 255);
            rspd = 255;
            if (lspd < 0)
                lspd = 0;
        end
        r.left_spd  = lspd[7:0];
        r.right_spd = rspd[7:0];
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Register write; the mirror follows right away since the block is idle.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_WHITE: white_lvl = data;
            CFG_SPAN:  span_cfg  = data;
            CFG_BASE:  base_cfg  = data[7:0];
            CFG_PGAIN: pgain_cfg = data[7:0];
            CFG_DGAIN: dgain_cfg = data[7:0];
            CFG_END:   end_cfg   = data[3:0];
            default: ;
        endcase
    endtask

    task automatic add_sample(input logic [15:0] ol, input logic [15:0] il,
                              input logic [15:0] ir, input logic [15:0] orr,
                              input logic [5:0] flag_bits);
        t_sample s;
        s.outer_l_lvl = ol;
        s.inner_l_lvl = il;
        s.inner_r_lvl = ir;
        s.outer_r_lvl = orr;
        s.flags       = t_flags'(flag_bits);
        if (s.flags.edge_l && s.flags.edge_r && edge_pairs_left > 0)
            edge_pairs_left--;
        sample_queue.push_back(s);
        n_queued++;
    endtask

    function automatic logic [15:0] rand_level();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(28000, 36000));
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly a contiguous run of inner flags as over a real line; sometimes
    // all inner flags off, sometimes noise. Both edges on at 1 in cross_odds.
    task automatic add_random_sample(input int cross_odds);
        logic [3:0] inner4;
        logic [1:0] edges;
        int         shape;
        int         center;
        shape = $urandom_range(0, 15);
        if (shape == 0) begin
            inner4 = 4'b0000;
        end else if (shape == 1) begin
            inner4 = 4'($urandom);
        end else begin
            center = $urandom_range(0, 3);
            inner4 = 4'b0001 << center;
            if ($urandom_range(0, 1) == 1 && center < 3)
                inner4 = inner4 | (inner4 << 1);
        end
        if (cross_odds > 0 && $urandom_range(1, cross_odds) == 1)
            edges = 2'b11;
        else
            edges = 2'($urandom_range(0, 2));
        add_sample(rand_level(), rand_level(), rand_level(), rand_level(),
                   {edges[1], inner4, edges[0]});
    endtask

    // Idle means every queued item accepted and every result back. Both
    // counts move only on rising edges, so this is polled on falling ones.
    task automatic wait_drained();
        while (n_accepted != n_queued || drive_expected.size() != 0)
            @(negedge i_clk);
    endtask

    // Settings per phase: reset values first, then the extremes, then random mixes.
    task automatic phase_config(input int phase);
        case (phase)
            0: begin
                cfg_write(CFG_WHITE, 16'($urandom));
                cfg_write(CFG_SPAN, RST_SPAN);
                cfg_write(CFG_BASE, 16'(RST_BASE));
                cfg_write(CFG_PGAIN, 16'(RST_PGAIN));
                cfg_write(CFG_DGAIN, 16'(RST_DGAIN));
                cfg_write(CFG_END, 16'hFFFF);  // masks down to 15
            end
            1: begin
                cfg_write(CFG_WHITE, 16'hFFFF);
                cfg_write(CFG_SPAN, 16'd1);
                cfg_write(CFG_BASE, 16'd255);
                cfg_write(CFG_PGAIN, 16'd255);
                cfg_write(CFG_DGAIN, 16'd255);
            end
            2: begin
                cfg_write(CFG_WHITE, 16'd0);
                cfg_write(CFG_SPAN, 16'hFFFF);
                cfg_write(CFG_BASE, 16'd0);
                cfg_write(CFG_PGAIN, 16'd0);
                cfg_write(CFG_DGAIN, 16'd0);
            end
            default: begin
                cfg_write(CFG_WHITE, 16'($urandom));
                if (phase == 3)
                    cfg_write(CFG_SPAN, 16'd0);
                else if (phase == 4)
                    cfg_write(CFG_SPAN, 16'($urandom));
                else
                    cfg_write(CFG_SPAN, 16'($urandom_range(1000, 40000)));
                // upper data bits set on purpose: only the low byte counts
                cfg_write(CFG_BASE, 16'($urandom));
                cfg_write(CFG_PGAIN, 16'($urandom));
                cfg_write(CFG_DGAIN, 16'($urandom));
                if (phase == 4) begin
                    cfg_write(CFG_SPARE_A, 16'($urandom));
                    cfg_write(CFG_SPARE_B, 16'($urandom));
                end
            end
        endcase
    endtask

    // Driver: presents queued samples, holds each until taken, then waits out
    // in_gap, drawn at random while idle_on is set, before the next one.
    always @(negedge i_clk) begin : sample_driver
        t_sample cur;
        if (i_rst_n && (!i_in_valid || in_took)) begin
            in_took = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
                cur = sample_queue.pop_front();
                i_outer_left_level  <= cur.outer_l_lvl;
                i_inner_left_level  <= cur.inner_l_lvl;
                i_inner_right_level <= cur.inner_r_lvl;
                i_outer_right_level <= cur.outer_r_lvl;
                i_edge_left_on      <= cur.flags.edge_l;
                i_outer_left_on     <= cur.flags.outer_l;
                i_inner_left_on     <= cur.flags.inner_l;
                i_inner_right_on    <= cur.flags.inner_r;
                i_outer_right_on    <= cur.flags.outer_r;
                i_edge_right_on     <= cur.flags.edge_r;
                i_in_valid          <= 1'b1;
                in_gap = idle_on ? $urandom_range(0, 3) : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls for a random out_wait after each result while idle_on is set; out_hold forces a long
    // hold-off so the block backs up into its input.
    always @(negedge i_clk) begin : drive_receiver
        if (out_took) begin
            out_took = 1'b0;
            out_wait = idle_on ? $urandom_range(0, 3) : 0;
        end
        if (out_hold > 0) begin
            out_hold--;
            i_out_stall <= 1'b1;
        end else if (out_wait > 0) begin
            out_wait--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: checks each taken result against the oldest prediction, then
    // predicts for a sample taken on the same edge.
    always @(posedge i_clk) begin : drive_monitor
        t_drive  got;
        t_drive  want;
        t_sample smp;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                out_took      = 1'b1;
                got.left_spd  = o_left_speed;
                got.right_spd = o_right_speed;
                got.spin      = o_search_turn;
                got.crossed   = o_crossing;
                got.count     = o_line_count;
                got.done      = o_course_done;
                got.line_ev   = o_line_event;
                if (drive_expected.size() == 0) begin
                    $display("%0t: drive result with none expected, expected none, actual %h",
                             $time, got);
                    n_errors++;
                end else begin
                    want = drive_expected.pop_front();
                    check_field("left_speed", want.left_spd, got.left_spd);
                    check_field("right_speed", want.right_spd, got.right_spd);
                    check_field("search_turn", want.spin, got.spin);
                    check_field("crossing", want.crossed, got.crossed);
                    check_field("line_count", want.count, got.count);
                    check_field("course_done", want.done, got.done);
                    check_field("line_event", want.line_ev, got.line_ev);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                in_took           = 1'b1;
                smp.outer_l_lvl   = i_outer_left_level;
                smp.inner_l_lvl   = i_inner_left_level;
                smp.inner_r_lvl   = i_inner_right_level;
                smp.outer_r_lvl   = i_outer_right_level;
                smp.flags.edge_l  = i_edge_left_on;
                smp.flags.outer_l = i_outer_left_on;
                smp.flags.inner_l = i_inner_left_on;
                smp.flags.inner_r = i_inner_right_on;
                smp.flags.outer_r = i_outer_right_on;
                smp.flags.edge_r  = i_edge_right_on;
                drive_expected.push_back(drive_predict(smp));
                n_accepted++;
            end
        end
    end

    initial begin : stimulus
        int phase;
        model_reset();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset register values (course ends at 3 crossings).
        // Flag order: edge_l outer_l inner_l inner_r outer_r edge_r.
        add_sample(16'd0, 16'd0, 16'd0, 16'd0, 6'b011110);              // dead center
        add_sample(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 6'b011110);        // + saturation, spill
        add_sample(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 6'b011110);        // - saturation
        add_sample(16'd30000, 16'd31000, 16'd29000, 16'd30500, 6'b011110);
        add_sample(16'd40000, 16'd20000, 16'd20000, 16'd20000, 6'b010010); // inner pair lost
        add_sample(16'd40000, 16'd20000, 16'd20000, 16'd20000, 6'b011110); // regained
        add_sample(16'd50000, 16'd0, 16'd0, 16'd0, 6'b000000);          // line lost, spin left
        add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'b000000);  // still searching
        add_sample(16'd1234, 16'd0, 16'd0, 16'd0, 6'b000100);           // search ends
        add_sample(16'd0, 16'd0, 16'd0, 16'd50000, 6'b001100);          // regain, error < 0
        add_sample(16'd0, 16'd0, 16'd0, 16'd60000, 6'b000000);          // lost, spin right
        add_sample(16'd0, 16'd0, 16'd0, 16'd0, 6'b011110);              // search ends
        add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'b111111);  // crossing counted
        add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'b111111);  // disarmed, no count
        add_sample(16'd100, 16'd200, 16'd300, 16'd400, 6'b101110);      // one edge: still off
        add_sample(16'd500, 16'd400, 16'd300, 16'd200, 6'b011110);      // edges clear: re-arm
        add_sample(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 6'b001010);
        add_sample(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 6'b010100);
        wait_drained();

        // Random phases, each under its own register setting.
        for (phase = 0; phase < 8; phase++) begin
            phase_config(phase);
            idle_on = (phase != 5);  // one phase runs flat out on both sides
            if (phase == 2) begin
                @(posedge i_clk);
                out_hold = 400;
            end
            repeat (235)
                add_random_sample(edge_pairs_left > 0 ? 80 : 0);
            wait_drained();
        end

        // Course end: either on the first item outside a line search or at the next crossing.
        idle_on = 1'b1;
        if ($urandom_range(0, 1) == 1)
            cfg_write(CFG_END, 16'd0);
        else
            cfg_write(CFG_END, 16'(lines_seen + 4'd1));
        repeat (40)
            add_random_sample(3);
        wait_drained();

        // catch anything the block still sends
        repeat (40) @(negedge i_clk);
        if (n_errors == 0)
            $display("pd_line_follower_drive_top test passed");
        else
            $display("pd_line_follower_drive_top test failed");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("pd_line_follower_drive_top test failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/pdlf_pkg.sv
rtl/pdlf_dpath.sv
rtl/pdlf_ctrl.sv
rtl/pd_line_follower_drive_top.sv
tb/tb.sv
